// File: sv/swa_pkg.sv
// Shared types, constants and the sine table of the sine texture warp address core.
package swa_pkg;

    localparam int MAX_DIM      = 1024;
    localparam int SINE_ENTRIES = 1024;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DVS_W   = (DIM_W > 5) ? DIM_W : 5;
    localparam int REM_W   = DVS_W + 1;
    localparam int SINE_AW = $clog2(SINE_ENTRIES + 1);

    // Spatial angle divider: numerator is dest << 19 in a 32-bit word, 4 bits a stage.
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_STAGES = DIV_NUM_W / 4;

    // Wrap unit: numerator is coordinate + displacement + 256 * dimension.
    localparam int NUM_W      = DIM_W + 9;
    localparam int REM_STAGES = (NUM_W + 3) / 4;
    localparam int REM_PAD    = 4 * REM_STAGES;
    localparam int CMB_W      = (NUM_W + 1 > 24) ? NUM_W + 1 : 24;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int LANES = 4;

    // Register indexes (word address).
    localparam logic [2:0] REG_WARP_MODE      = 3'd0;
    localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_X_SCALE        = 3'd3;
    localparam logic [2:0] REG_Y_SCALE        = 3'd4;
    localparam logic [2:0] REG_FRAME_TIME     = 3'd5;

    localparam logic MODE_SHIFT  = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    // Per lane rates (1/65536 turn per second) and phases (1/65536 turn), {lane3..lane0}.
    // Shift warp: lane0 column term, lane1 row term; lanes 2 and 3 unused.
    // Double warp: lane0 s3, lane1 s1, lane2 s2, lane3 s4.
    localparam logic [LANES-1:0][15:0] RATE_M0 = {16'd45714, 16'd21543, 16'd9102, 16'd8010};
    localparam logic [LANES-1:0][15:0] RATE_M1 = {16'd45714, 16'd21543, 16'd57143, 16'd45714};
    localparam logic [LANES-1:0][15:0] OFF_M0  = {16'd9599, 16'd5600, 16'd0, 16'd17408};
    localparam logic [LANES-1:0][15:0] OFF_M1  = {16'd9599, 16'd5600, 16'd7200, 16'd2399};

    typedef struct packed {
        logic [9:0] dest_x;
        logic [9:0] dest_y;
    } t_in;

    typedef struct packed {
        logic [9:0]  source_x;
        logic [9:0]  source_y;
        logic [19:0] source_index;
    } t_out;

    typedef struct packed {
        logic mode;
        t_in  pix;
    } t_qent;

    typedef struct packed {
        logic [DIM_W-1:0]            w;
        logic [DIM_W-1:0]            h;
        logic [4:0]                  xs;
        logic [4:0]                  ys;
        logic [LANES-1:0][23:0]      lane_off;
    } t_geom;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [3:0]       q;
    } t_div_step;

    // Four restoring division steps; rem_in must be below dvs.
    function automatic t_div_step f_div_step(input logic [REM_W-1:0] rem_in,
                                             input logic [3:0]       bits,
                                             input logic [DVS_W-1:0] dvs);
        logic [REM_W-1:0] rem;
        t_div_step        res;
        rem   = rem_in;
        res.q = '0;
        for (int j = 3; j >= 0; j--) begin
            rem = {rem[REM_W-2:0], bits[j]};
            if (rem >= REM_W'(dvs)) begin
                rem      = rem - REM_W'(dvs);
                res.q[j] = 1'b1;
            end
        end
        res.rem = rem;
        return res;
    endfunction

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [14:0] t_sine_rom [0:SINE_ENTRIES];

    // Quarter wave in Q14 from a Q30 Taylor series, built at elaboration.
    function automatic t_sine_rom f_sine_rom();
        t_sine_rom       rom;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned h;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            t  = (longint'(k) * HALF_PI_Q30) / SINE_ENTRIES;
            t2 = (t * t) >> 30;
            h  = Q30_ONE - t2 / 110;
            h  = Q30_ONE - (((t2 / 72) * h) >> 30);
            h  = Q30_ONE - (((t2 / 42) * h) >> 30);
            h  = Q30_ONE - (((t2 / 20) * h) >> 30);
            h  = Q30_ONE - (((t2 / 6) * h) >> 30);
            rom[k] = 15'((((t * h) >> 30) + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_sine_rom();

endpackage

// File: sv/swa_front.sv
// Front end: register port, item intake and per-frame angle offsets.
module swa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  swa_pkg::t_in        i_item,
    input  logic                i_room,
    output logic                o_push,
    output swa_pkg::t_qent      o_ent,
    output swa_pkg::t_geom      o_geom
);

    logic        r_warp_mode;
    logic [10:0] r_texture_width;
    logic [10:0] r_texture_height;
    logic [4:0]  r_x_scale;
    logic [4:0]  r_y_scale;
    logic [23:0] r_frame_time;

    logic           r_fv;
    swa_pkg::t_qent r_fent;
    swa_pkg::t_geom r_geom;
    swa_pkg::t_geom n_geom;

    logic        wr_en;
    logic        accept;
    logic [39:0] n_mul [swa_pkg::LANES];

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign busy   = ~i_room;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warp_mode      <= 1'b0;
            r_texture_width  <= 11'd64;
            r_texture_height <= 11'd64;
            r_x_scale        <= 5'd1;
            r_y_scale        <= 5'd1;
            r_frame_time     <= 24'd0;
        end else if (wr_en) begin
            case (paddr[4:2])
                swa_pkg::REG_WARP_MODE:      r_warp_mode      <= pwdata[0];
                swa_pkg::REG_TEXTURE_WIDTH:  r_texture_width  <= pwdata[10:0];
                swa_pkg::REG_TEXTURE_HEIGHT: r_texture_height <= pwdata[10:0];
                swa_pkg::REG_X_SCALE:        r_x_scale        <= pwdata[4:0];
                swa_pkg::REG_Y_SCALE:        r_y_scale        <= pwdata[4:0];
                swa_pkg::REG_FRAME_TIME:     r_frame_time     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            swa_pkg::REG_WARP_MODE:      prdata = {31'd0, r_warp_mode};
            swa_pkg::REG_TEXTURE_WIDTH:  prdata = {21'd0, r_texture_width};
            swa_pkg::REG_TEXTURE_HEIGHT: prdata = {21'd0, r_texture_height};
            swa_pkg::REG_X_SCALE:        prdata = {27'd0, r_x_scale};
            swa_pkg::REG_Y_SCALE:        prdata = {27'd0, r_y_scale};
            swa_pkg::REG_FRAME_TIME:     prdata = {8'd0, r_frame_time};
            default:                     prdata = 32'd0;
        endcase
    end

    // Clamp dimensions to 1..MAX_DIM, zero scale acts as one.
    always_comb begin
        if (r_texture_width == 11'd0) begin
            n_geom.w = swa_pkg::DIM_W'(1);
        end else if (32'(r_texture_width) > swa_pkg::MAX_DIM) begin
            n_geom.w = swa_pkg::DIM_W'(swa_pkg::MAX_DIM);
        end else begin
            n_geom.w = swa_pkg::DIM_W'(r_texture_width);
        end
        if (r_texture_height == 11'd0) begin
            n_geom.h = swa_pkg::DIM_W'(1);
        end else if (32'(r_texture_height) > swa_pkg::MAX_DIM) begin
            n_geom.h = swa_pkg::DIM_W'(swa_pkg::MAX_DIM);
        end else begin
            n_geom.h = swa_pkg::DIM_W'(r_texture_height);
        end
        n_geom.xs = (r_x_scale == 5'd0) ? 5'd1 : r_x_scale;
        n_geom.ys = (r_y_scale == 5'd0) ? 5'd1 : r_y_scale;
        for (int l = 0; l < swa_pkg::LANES; l++) begin
            n_mul[l] = r_frame_time * (r_warp_mode ? swa_pkg::RATE_M1[l]
                                                   : swa_pkg::RATE_M0[l]);
            n_geom.lane_off[l] = n_mul[l][23:0]
                + {(r_warp_mode ? swa_pkg::OFF_M1[l] : swa_pkg::OFF_M0[l]), 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
        if (accept) begin
            r_fent.mode <= r_warp_mode;
            r_fent.pix  <= i_item;
        end
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept;
        end
    end

    assign o_push = r_fv;
    assign o_ent  = r_fent;
    assign o_geom = r_geom;

endmodule

// File: sv/swa_queue.sv
// Short queue between the front end and the address pipeline.
module swa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swa_pkg::t_qent i_ent,
    output logic           o_room,
    output logic           o_valid,
    output swa_pkg::t_qent o_ent
);

    swa_pkg::t_qent              r_mem [swa_pkg::Q_DEPTH];
    logic [swa_pkg::QPTR_W-1:0]  r_wp;
    logic [swa_pkg::QPTR_W-1:0]  r_rp;
    logic [swa_pkg::QCNT_W-1:0]  r_count;
    logic [swa_pkg::QCNT_W-1:0]  n_count;
    logic                        pop;

    // The pipeline behind never stalls: drain one entry every cycle.
    assign pop     = (r_count != '0);
    assign o_valid = pop;
    assign o_ent   = r_mem[r_rp];
    // Keep one slot spare for the item held in the front register.
    assign o_room  = (r_count < swa_pkg::QCNT_W'(swa_pkg::Q_DEPTH - 1));

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

// File: sv/swa_back.sv
// Address pipeline: angle divide, sine lookup, scaling, wrap and index.
module swa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swa_pkg::t_geom i_geom,
    input  logic           i_valid,
    input  swa_pkg::t_qent i_ent,
    output logic           o_valid,
    output swa_pkg::t_out  o_res
);

    localparam int ST_PH  = swa_pkg::DIV_STAGES;
    localparam int ST_ROM = ST_PH + 1;
    localparam int ST_MUL = ST_PH + 2;
    localparam int ST_CMB = ST_PH + 3;
    localparam int ST_REM = ST_PH + 4;
    localparam int ST_OUT = ST_REM + swa_pkg::REM_STAGES;
    localparam int BACK_LAT = ST_OUT + 1;

    localparam int DS = swa_pkg::DIV_STAGES;
    localparam int RS = swa_pkg::REM_STAGES;
    localparam int LN = swa_pkg::LANES;

    logic r_v [BACK_LAT];

    // Angle divider stages.
    swa_pkg::t_qent                r_dent [DS];
    logic [swa_pkg::REM_W-1:0]     r_dxr  [DS];
    logic [swa_pkg::REM_W-1:0]     r_dyr  [DS];
    logic [swa_pkg::DIV_NUM_W-1:0] r_dxq  [DS];
    logic [swa_pkg::DIV_NUM_W-1:0] r_dyq  [DS];
    swa_pkg::t_div_step            st_x   [DS];
    swa_pkg::t_div_step            st_y   [DS];
    logic [swa_pkg::DIV_NUM_W-1:0] num_x  [DS];
    logic [swa_pkg::DIV_NUM_W-1:0] num_y  [DS];

    // Sine stages.
    swa_pkg::t_qent               r_pent;
    logic [swa_pkg::SINE_AW-1:0]  r_k   [LN];
    logic                         r_neg [LN];
    logic [swa_pkg::SINE_AW-1:0]  n_k   [LN];
    logic                         n_neg [LN];
    logic [23:0]                  spat  [LN];
    logic [23:0]                  phase [LN];
    logic [31:0]                  idx_i [LN];
    logic [31:0]                  idx_k [LN];
    swa_pkg::t_qent               r_sent;
    logic signed [15:0]           r_sine [LN];
    logic signed [15:0]           n_sine [LN];
    swa_pkg::t_qent               r_ment;
    logic signed [21:0]           r_prod [LN];
    logic signed [5:0]            scl    [LN];

    // Combine and wrap stages.
    logic signed [swa_pkg::CMB_W-1:0] ex;
    logic signed [swa_pkg::CMB_W-1:0] ey;
    logic [swa_pkg::CMB_W-1:0]        n_nx;
    logic [swa_pkg::CMB_W-1:0]        n_ny;
    logic [swa_pkg::NUM_W-1:0]        r_nx [RS];
    logic [swa_pkg::NUM_W-1:0]        r_ny [RS];
    logic [swa_pkg::REM_W-1:0]        r_rxr [RS];
    logic [swa_pkg::REM_W-1:0]        r_ryr [RS];
    swa_pkg::t_div_step               sr_x  [RS];
    swa_pkg::t_div_step               sr_y  [RS];
    logic [swa_pkg::REM_PAD-1:0]      pad_x [RS];
    logic [swa_pkg::REM_PAD-1:0]      pad_y [RS];

    logic [swa_pkg::DIM_W-1:0] sx;
    logic [swa_pkg::DIM_W-1:0] sy;
    logic [31:0]               n_idx;
    swa_pkg::t_out             r_out;

    // Quotient of (dest << 19) / scale, four bits a stage.
    always_comb begin
        num_x[0] = {3'd0, i_ent.pix.dest_x, 19'd0};
        num_y[0] = {3'd0, i_ent.pix.dest_y, 19'd0};
        st_x[0]  = swa_pkg::f_div_step('0, num_x[0][31:28], swa_pkg::DVS_W'(i_geom.xs));
        st_y[0]  = swa_pkg::f_div_step('0, num_y[0][31:28], swa_pkg::DVS_W'(i_geom.ys));
        for (int s = 1; s < DS; s++) begin
            num_x[s] = {3'd0, r_dent[s-1].pix.dest_x, 19'd0};
            num_y[s] = {3'd0, r_dent[s-1].pix.dest_y, 19'd0};
            st_x[s]  = swa_pkg::f_div_step(r_dxr[s-1], num_x[s][31-4*s -: 4],
                                           swa_pkg::DVS_W'(i_geom.xs));
            st_y[s]  = swa_pkg::f_div_step(r_dyr[s-1], num_y[s][31-4*s -: 4],
                                           swa_pkg::DVS_W'(i_geom.ys));
        end
    end

    always_ff @(posedge i_clk) begin
        r_dent[0] <= i_ent;
        r_dxr[0]  <= st_x[0].rem;
        r_dyr[0]  <= st_y[0].rem;
        r_dxq[0]  <= {28'd0, st_x[0].q};
        r_dyq[0]  <= {28'd0, st_y[0].q};
        for (int s = 1; s < DS; s++) begin
            r_dent[s] <= r_dent[s-1];
            r_dxr[s]  <= st_x[s].rem;
            r_dyr[s]  <= st_y[s].rem;
            r_dxq[s]  <= {r_dxq[s-1][27:0], st_x[s].q};
            r_dyq[s]  <= {r_dyq[s-1][27:0], st_y[s].q};
        end
    end

    // Angle per lane, then quadrant fold into a ROM address.
    always_comb begin
        spat[0] = (r_dent[DS-1].mode == swa_pkg::MODE_DOUBLE) ? r_dxq[DS-1][23:0]
                                                              : r_dxq[DS-1][24:1];
        spat[1] = r_dyq[DS-1][24:1];
        spat[2] = r_dyq[DS-1][24:1];
        spat[3] = r_dxq[DS-1][23:0];
        for (int l = 0; l < LN; l++) begin
            phase[l] = spat[l] + i_geom.lane_off[l];
            idx_i[l] = (32'(phase[l][21:8]) * 32'(swa_pkg::SINE_ENTRIES)) >> 14;
            idx_k[l] = phase[l][22] ? (32'(swa_pkg::SINE_ENTRIES) - idx_i[l]) : idx_i[l];
            n_k[l]   = swa_pkg::SINE_AW'(idx_k[l]);
            n_neg[l] = phase[l][23];
        end
    end

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            n_sine[l] = r_neg[l] ? -$signed({1'b0, swa_pkg::SINE_ROM[r_k[l]]})
                                 :  $signed({1'b0, swa_pkg::SINE_ROM[r_k[l]]});
        end
        scl[0] = (r_sent.mode == swa_pkg::MODE_DOUBLE) ? $signed({1'b0, i_geom.xs})
                                                      : $signed({1'b0, i_geom.ys});
        scl[1] = $signed({1'b0, i_geom.xs});
        scl[2] = $signed({1'b0, i_geom.ys});
        scl[3] = $signed({1'b0, i_geom.ys});
    end

    always_ff @(posedge i_clk) begin
        r_pent <= r_dent[DS-1];
        r_sent <= r_pent;
        r_ment <= r_sent;
        for (int l = 0; l < LN; l++) begin
            r_k[l]    <= n_k[l];
            r_neg[l]  <= n_neg[l];
            r_sine[l] <= n_sine[l];
            r_prod[l] <= r_sine[l] * scl[l];
        end
    end

    // Displacement with floors; adding 256 * dimension keeps the sum positive.
    always_comb begin
        if (r_ment.mode == swa_pkg::MODE_DOUBLE) begin
            ex = (swa_pkg::CMB_W'(r_prod[1] >>> 5) + swa_pkg::CMB_W'(r_prod[0] >>> 5)) >>> 8;
            ey = (swa_pkg::CMB_W'(r_prod[2] >>> 5) + swa_pkg::CMB_W'(r_prod[3] >>> 5)) >>> 8;
        end else begin
            ex = swa_pkg::CMB_W'(r_prod[1] >>> 11);
            ey = swa_pkg::CMB_W'(r_prod[0] >>> 11);
        end
        n_nx = ex + swa_pkg::CMB_W'(r_ment.pix.dest_x) + (swa_pkg::CMB_W'(i_geom.w) << 8);
        n_ny = ey + swa_pkg::CMB_W'(r_ment.pix.dest_y) + (swa_pkg::CMB_W'(i_geom.h) << 8);
    end

    // Remainder by width and height, four bits a stage.
    always_comb begin
        for (int j = 0; j < RS; j++) begin
            pad_x[j] = swa_pkg::REM_PAD'(r_nx[j]);
            pad_y[j] = swa_pkg::REM_PAD'(r_ny[j]);
            sr_x[j]  = swa_pkg::f_div_step((j == 0) ? '0 : r_rxr[(j == 0) ? 0 : j-1],
                                           pad_x[j][swa_pkg::REM_PAD-1-4*j -: 4],
                                           swa_pkg::DVS_W'(i_geom.w));
            sr_y[j]  = swa_pkg::f_div_step((j == 0) ? '0 : r_ryr[(j == 0) ? 0 : j-1],
                                           pad_y[j][swa_pkg::REM_PAD-1-4*j -: 4],
                                           swa_pkg::DVS_W'(i_geom.h));
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx[0] <= n_nx[swa_pkg::NUM_W-1:0];
        r_ny[0] <= n_ny[swa_pkg::NUM_W-1:0];
        for (int j = 1; j < RS; j++) begin
            r_nx[j] <= r_nx[j-1];
            r_ny[j] <= r_ny[j-1];
        end
        for (int j = 0; j < RS; j++) begin
            r_rxr[j]  <= sr_x[j].rem;
            r_ryr[j]  <= sr_y[j].rem;
        end
    end

    assign sx    = swa_pkg::DIM_W'(r_rxr[RS-1]);
    assign sy    = swa_pkg::DIM_W'(r_ryr[RS-1]);
    assign n_idx = 32'(sy) * 32'(i_geom.w) + 32'(sx);

    always_ff @(posedge i_clk) begin
        r_out.source_x     <= 10'(sx);
        r_out.source_y     <= 10'(sy);
        r_out.source_index <= n_idx[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < BACK_LAT; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s < BACK_LAT; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    assign o_valid = r_v[BACK_LAT-1];
    assign o_res   = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##BACK_LAT o_valid)
        else $error("popped entry did not reach the output");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, BACK_LAT))
        else $error("result without a matching entry");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_res.source_x) < 32'(i_geom.w)))
        else $error("source_x not below width");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_res.source_y) < 32'(i_geom.h)))
        else $error("source_y not below height");

endmodule

// File: sv/sine_texture_warp_address_core.sv
// Top level of the sine texture warp address core.
//
// Each destination pixel (dest_x, dest_y) presented with start while busy is
// low is one transaction; the core returns the warped source pixel and its
// linear index source_x + source_y * width. One transaction is taken every
// clock cycle while busy is low, and its result is shown on o_result for
// exactly one cycle with o_result_valid high, after it has passed the intake
// register, the queue and the back-end pipeline. That pipeline holds the
// 8-stage angle divider (pixel / scale, four quotient bits a stage), the sine
// table and scaling stages, and the 5-stage wrap unit that takes the
// remainder by width and height. The receiver cannot stall; busy only rises
// if the internal queue backs up, which the never-stalling pipeline behind it
// prevents. Write registers only while no transaction is in flight.
module sine_texture_warp_address_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // pixel transactions
    input  logic          start,
    output logic          busy,
    input  swa_pkg::t_in  i_item,
    output logic          o_result_valid,
    output swa_pkg::t_out o_result
);

    logic           push;
    logic           room;
    logic           q_valid;
    swa_pkg::t_qent push_ent;
    swa_pkg::t_qent q_ent;
    swa_pkg::t_geom geom;

    // Front end: registers, clamped geometry, per-frame angle offsets and
    // the intake register that tags each pixel with the warp mode.
    swa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_room  (room),
        .o_push  (push),
        .o_ent   (push_ent),
        .o_geom  (geom)
    );

    // Decouple intake from the pipeline; drained one entry per cycle.
    swa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_room  (room),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    // Back end: divide, sine lookup, scale, wrap, index; advances every cycle.
    swa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (q_valid),
        .i_ent   (q_ent),
        .o_valid (o_result_valid),
        .o_res   (o_result)
    );

endmodule

// File: verif/tb.sv
// Self-checking testbench of the sine texture warp address core.
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY   = 20;
    localparam int WDOG_MAX  = 5000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          start = 1'b0;
    logic          busy;
    swa_pkg::t_in  i_item = '0;
    logic          o_result_valid;
    swa_pkg::t_out o_result;

    // Shadow copy of the register file.
    logic        sh_mode = swa_pkg::MODE_SHIFT;
    logic [10:0] sh_w = 11'd64;
    logic [10:0] sh_h = 11'd64;
    logic [4:0]  sh_xs = 5'd1;
    logic [4:0]  sh_ys = 5'd1;
    logic [23:0] sh_time = '0;

    swa_pkg::t_out warp_expected[$];
    int            n_errors = 0;
    int            idle_cycles = 0;
    bit            quiet_sender = 1'b0;
    logic [14:0]   quarter_wave [0:swa_pkg::SINE_ENTRIES];

    always #4 i_clk = ~i_clk;

    sine_texture_warp_address_core dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .start, .busy, .i_item, .o_result_valid, .o_result
    );

    // Build the quarter-wave table independently in Q30 fixed point.
    initial begin
        longint unsigned t, t2, hh;
        for (int k = 0; k <= swa_pkg::SINE_ENTRIES; k++) begin
            t  = (64'(k) * 64'd1686629713) / swa_pkg::SINE_ENTRIES;
            t2 = (t * t) >> 30;
            hh = 64'd1073741824 - t2 / 110;
            hh = 64'd1073741824 - (((t2 / 72) * hh) >> 30);
            hh = 64'd1073741824 - (((t2 / 42) * hh) >> 30);
            hh = 64'd1073741824 - (((t2 / 20) * hh) >> 30);
            hh = 64'd1073741824 - (((t2 / 6) * hh) >> 30);
            quarter_wave[k] = 15'((((t * hh) >> 30) + 64'd32768) >> 16);
        end
    end

    function automatic longint sine_q14(input logic [31:0] ang);
        logic [15:0] a;
        int          idx;
        longint      s;
        a   = ang[23:8];
        idx = (int'(a[13:0]) * swa_pkg::SINE_ENTRIES) >>> 14;
        if (a[14]) idx = swa_pkg::SINE_ENTRIES - idx;
        s = longint'(quarter_wave[idx]);
        return a[15] ? -s : s;
    endfunction

    function automatic logic [31:0] lane_angle(input logic [9:0] pix, input int shl,
                                               input int scl, input int rate,
                                               input int ofs);
        logic [31:0] sp, tm;
        sp = 32'((64'(pix) << shl) / scl);
        tm = 32'(64'(sh_time) * rate);
        return sp + tm + 32'(ofs << 8);
    endfunction

    function automatic longint floor_div(input longint v, input int n);
        return v >>> n;  // arithmetic shift is a floor for signed values
    endfunction

    function automatic longint pos_mod(input longint v, input longint m);
        longint r;
        r = v % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic swa_pkg::t_out warp_address(input swa_pkg::t_in px);
        longint        w, h, xs, ys, sx, sy, x, y, s1, s2, s3, s4, d8x, d8y;
        swa_pkg::t_out r;
        w  = sh_w < 1 ? 1 : (sh_w > swa_pkg::MAX_DIM ? swa_pkg::MAX_DIM : sh_w);
        h  = sh_h < 1 ? 1 : (sh_h > swa_pkg::MAX_DIM ? swa_pkg::MAX_DIM : sh_h);
        xs = sh_xs == 0 ? 1 : sh_xs;
        ys = sh_ys == 0 ? 1 : sh_ys;
        x  = px.dest_x;
        y  = px.dest_y;
        if (sh_mode == swa_pkg::MODE_SHIFT) begin
            s1  = sine_q14(lane_angle(px.dest_x, 18, int'(xs), 8010, 17408));
            s2  = sine_q14(lane_angle(px.dest_y, 18, int'(ys), 9102, 0));
            d8x = floor_div(s2 * xs, 3) + 2048 * xs * w;
            d8y = floor_div(s1 * ys, 3) + 2048 * ys * h;
            sx  = pos_mod(floor_div(d8x, 8) + x, w);
            sy  = pos_mod(floor_div(d8y, 8) + y, h);
        end else begin
            s1  = sine_q14(lane_angle(px.dest_y, 18, int'(ys), 57143, 7200));
            s2  = sine_q14(lane_angle(px.dest_y, 18, int'(ys), 21543, 5600));
            s3  = sine_q14(lane_angle(px.dest_x, 19, int'(xs), 45714, 2399));
            s4  = sine_q14(lane_angle(px.dest_x, 19, int'(xs), 45714, 9599));
            d8x = 256 * x + 512 * w * xs + floor_div(s1 * xs, 5) + floor_div(s3 * xs, 5);
            d8y = 256 * y + 512 * h * ys + floor_div(s2 * ys, 5) + floor_div(s4 * ys, 5);
            sx  = pos_mod(floor_div(d8x, 8), w);
            sy  = pos_mod(floor_div(d8y, 8), h);
        end
        r.source_x     = 10'(sx);
        r.source_y     = 10'(sy);
        r.source_index = 20'(sx + sy * w);
        return r;
    endfunction

    // Compare every result strobe against the oldest expectation.
    always @(posedge i_clk) begin
        swa_pkg::t_out exp_r;
        if (i_rst_n && o_result_valid) begin
            if (warp_expected.size() == 0) begin
                $error("unexpected result %h", o_result);
                n_errors++;
            end else begin
                exp_r = warp_expected.pop_front();
                if (o_result.source_x !== exp_r.source_x) begin
                    $error("source_x exp %0d got %0d", exp_r.source_x, o_result.source_x);
                    n_errors++;
                end
                if (o_result.source_y !== exp_r.source_y) begin
                    $error("source_y exp %0d got %0d", exp_r.source_y, o_result.source_y);
                    n_errors++;
                end
                if (o_result.source_index !== exp_r.source_index) begin
                    $error("source_index exp %0d got %0d", exp_r.source_index,
                           o_result.source_index);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles without an accepted transaction, a result or a register write.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("sine_texture_warp_address_core test failed");
            $finish;
        end
    end

    // Write one register: setup phase then access phase.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            swa_pkg::REG_WARP_MODE:      sh_mode = val[0];
            swa_pkg::REG_TEXTURE_WIDTH:  sh_w    = val[10:0];
            swa_pkg::REG_TEXTURE_HEIGHT: sh_h    = val[10:0];
            swa_pkg::REG_X_SCALE:        sh_xs   = val[4:0];
            swa_pkg::REG_Y_SCALE:        sh_ys   = val[4:0];
            swa_pkg::REG_FRAME_TIME:     sh_time = val[23:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (warp_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Send one pixel; hold start high and leave it for the next call or a gap.
    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        swa_pkg::t_in px;
        if (!quiet_sender && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        px.dest_x = x;
        px.dest_y = y;
        start  <= 1'b1;
        i_item <= px;
        do @(posedge i_clk); while (busy);
        warp_expected.push_back(warp_address(px));
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic m, input int w, input int h, input int xs,
                             input int ys, input int tm);
        stop_sending();
        wait_drained();
        write_reg(swa_pkg::REG_WARP_MODE, 32'(m));
        write_reg(swa_pkg::REG_TEXTURE_WIDTH, 32'(w));
        write_reg(swa_pkg::REG_TEXTURE_HEIGHT, 32'(h));
        write_reg(swa_pkg::REG_X_SCALE, 32'(xs));
        write_reg(swa_pkg::REG_Y_SCALE, 32'(ys));
        write_reg(swa_pkg::REG_FRAME_TIME, 32'(tm));
    endtask

    // Directed corners: field extremes, both modes, clamps and zero scales.
    task automatic test_directed();
        configure(swa_pkg::MODE_SHIFT, 64, 64, 1, 1, 0);
        send_pixel(0, 0);
        send_pixel(10'h3ff, 10'h3ff);
        send_pixel(63, 0);
        send_pixel(10'h2aa, 10'h155);
        configure(swa_pkg::MODE_DOUBLE, 1024, 1024, 16, 16, 24'hffffff);
        send_pixel(0, 0);
        send_pixel(10'h3ff, 10'h3ff);
        send_pixel(10'h155, 10'h2aa);
        configure(swa_pkg::MODE_SHIFT, 0, 2047, 0, 31, 24'h800000);   // clamps, zero scale
        send_pixel(5, 1000);
        send_pixel(10'h3ff, 0);
        configure(swa_pkg::MODE_DOUBLE, 1, 1, 17, 0, 1);
        send_pixel(10'h3ff, 10'h3ff);
        send_pixel(1, 2);
        configure(swa_pkg::MODE_SHIFT, 1024, 3, 16, 1, 12345);
        send_pixel(10'h3ff, 10'h3ff);
        send_pixel(512, 2);
    endtask

    // Random pixels over several random configurations.
    task automatic test_random();
        for (int phase = 0; phase < 12; phase++) begin
            int w, h;
            w = $urandom_range(99) < 10 ? $urandom_range(2047) : $urandom_range(1, 1024);
            h = $urandom_range(99) < 10 ? $urandom_range(2047) : $urandom_range(1, 1024);
            configure(1'($urandom_range(1)), w, h, $urandom_range(31), $urandom_range(31),
                      $urandom_range(24'hffffff));
            quiet_sender = (phase == 5);
            for (int n = 0; n < 160; n++) begin
                if ($urandom_range(99) < 85)
                    send_pixel(10'($urandom_range(w > 0 ? w - 1 : 0)),
                               10'($urandom_range(h > 0 ? h - 1 : 0)));
                else
                    send_pixel(10'($urandom), 10'($urandom));
                if (n == 80 && phase == 3) begin
                    // hold off until everything in flight has come back
                    stop_sending();
                    while (warp_expected.size() != 0) @(posedge i_clk);
                end
            end
            quiet_sender = 1'b0;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        stop_sending();
        wait_drained();
        if (n_errors == 0)
            $display("sine_texture_warp_address_core test passed");
        else
            $display("sine_texture_warp_address_core test failed");
        $finish;
    end

endmodule
